### rtl/ipu_pkg.sv
// Shared types and constants for the pixel replication upscaler.
`default_nettype none

package ipu_pkg;

  // Widths fixed by the field and register definitions
  localparam int unsigned FactorW = 7;
  localparam int unsigned RowsW   = 11;
  localparam int unsigned PixW    = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [FactorW-1:0] FACTOR_MAX = 7'd99;
  localparam logic [7:0]         PAD_BYTE   = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_PIXEL  = 3'd1,
    ST_PAD    = 3'd2,
    ST_ACCEPT = 3'd3,
    ST_REJECT = 3'd4
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REPEAT_FACTOR = 2'd0,
    REG_ROW_PIXELS    = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_word_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       row_end;
    logic       block_end;
  } out_word_t;

  // Per-word info carried from the control stage to the output register
  typedef struct packed {
    status_t status;
    logic    row_end;
    logic    block_end;
  } res_meta_t;

endpackage

`default_nettype wire

### rtl/ipu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module ipu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/integer_pixel_replication_upscaler_top.sv
// Top level of the integer pixel replication upscaler: control, line buffer, output stage.
//
//  channel  dir  handshake              payload
//  item     in   item_valid/item_ready  item (in_word_t): kind, blue, green, red
//  res      out  res_valid/res_ready    res (out_word_t): status, bytes, row_end, block_end
//  cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data (0 repeat_factor, 1 row_pixels)
//
// Sustained rate is one word per cycle while res_ready is high: each word issues one line
// buffer read, and an accepted pixel also does a write, on the single RAM port pair.
// Words pass through the control stage (counters update, RAM read issued), then
// the output register, which picks up the RAM read data.
// Up to two words are held in flight; a stalled res side backs up into item_ready.
// Synchronous reset clears the counters and flags; the line buffer is not cleared.
`default_nettype none

module integer_pixel_replication_upscaler_top
  import ipu_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire in_word_t           item,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output out_word_t               res,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [RowsW-1:0]   cfg_data
);

  localparam int unsigned AddrW    = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam logic [31:0] MaxRowsW = 32'(MAX_ROW_PIXELS);

  // ---------------------------------------------------------------- config
  logic [FactorW-1:0] repeat_factor;
  logic [RowsW-1:0]   row_pixels;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_factor <= FactorW'(1);
      row_pixels    <= RowsW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REPEAT_FACTOR: repeat_factor <= cfg_data[FactorW-1:0];
        REG_ROW_PIXELS:    row_pixels    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range values are clamped, not rejected
  logic [FactorW-1:0] eff_factor;
  logic [RowsW-1:0]   eff_rows;
  logic [3:0]         pad_prod;
  logic [1:0]         pad_len;

  always_comb begin
    if (repeat_factor == '0) begin
      eff_factor = FactorW'(1);
    end else if (repeat_factor > FACTOR_MAX) begin
      eff_factor = FACTOR_MAX;
    end else begin
      eff_factor = repeat_factor;
    end

    if (row_pixels == '0) begin
      eff_rows = RowsW'(1);
    end else if (32'(row_pixels) > MaxRowsW) begin
      eff_rows = RowsW'(MaxRowsW);
    end else begin
      eff_rows = row_pixels;
    end
  end

  // Row bytes are 3*rows*factor; padding to a multiple of 4 is
  // (-3*rows*factor) mod 4, which equals (rows*factor) mod 4.
  assign pad_prod = {2'b00, eff_rows[1:0]} * {2'b00, eff_factor[1:0]};
  assign pad_len  = pad_prod[1:0];

  // ---------------------------------------------------------------- control state
  logic [RowsW-1:0]   fill_position, fill_position_next;
  logic               row_ready, row_ready_next;
  logic [RowsW-1:0]   read_position, read_position_next;
  logic [FactorW-1:0] horizontal_count, horizontal_count_next;
  logic [FactorW-1:0] vertical_count, vertical_count_next;
  logic [1:0]         pad_count, pad_count_next;
  logic               in_padding, in_padding_next;

  // Pipeline: s1 holds the word whose RAM read is in flight, res is the output register
  logic      s1_valid;
  res_meta_t s1_meta;
  logic      s1_move;
  logic      accept;

  res_meta_t          meta_next;
  logic               ram_we;
  logic [PixW-1:0]    ram_rdata;

  logic [RowsW-1:0]   fill_inc;
  logic [RowsW-1:0]   read_inc;
  logic [FactorW-1:0] h_inc;
  logic [FactorW-1:0] v_inc;
  logic [2:0]         p_inc;
  logic               finish;

  assign s1_move    = s1_valid && (!res_valid || res_ready);
  assign item_ready = !s1_valid || !res_valid || res_ready;
  assign accept     = item_valid && item_ready;

  assign fill_inc = fill_position + RowsW'(1);
  assign read_inc = read_position + RowsW'(1);
  assign h_inc    = horizontal_count + FactorW'(1);
  assign v_inc    = vertical_count + FactorW'(1);
  assign p_inc    = {1'b0, pad_count} + 3'd1;

  always_comb begin
    fill_position_next    = fill_position;
    row_ready_next        = row_ready;
    read_position_next    = read_position;
    horizontal_count_next = horizontal_count;
    vertical_count_next   = vertical_count;
    pad_count_next        = pad_count;
    in_padding_next       = in_padding;
    meta_next             = '{status: ST_IDLE, row_end: 1'b0, block_end: 1'b0};
    ram_we                = 1'b0;
    finish                = 1'b0;

    if (item.kind == KIND_PIXEL) begin
      if (row_ready) begin
        meta_next.status = ST_REJECT;
      end else begin
        meta_next.status = ST_ACCEPT;
        ram_we           = 1'b1;
        if (fill_inc >= eff_rows) begin
          fill_position_next    = '0;
          row_ready_next        = 1'b1;
          read_position_next    = '0;
          horizontal_count_next = '0;
          vertical_count_next   = '0;
          pad_count_next        = '0;
          in_padding_next       = 1'b0;
        end else begin
          fill_position_next = fill_inc;
        end
      end
    end else if (row_ready) begin
      if (in_padding) begin
        meta_next.status = ST_PAD;
        pad_count_next   = p_inc[1:0];
        if (p_inc >= {1'b0, pad_len}) begin
          finish = 1'b1;
        end
      end else begin
        meta_next.status = ST_PIXEL;
        if (h_inc >= eff_factor) begin
          horizontal_count_next = '0;
          if (read_inc >= eff_rows) begin
            if (pad_len == 2'd0) begin
              finish = 1'b1;
            end else begin
              in_padding_next = 1'b1;
              pad_count_next  = '0;
            end
          end else begin
            read_position_next = read_inc;
          end
        end else begin
          horizontal_count_next = h_inc;
        end
      end
    end

    // End of one output row; the last vertical copy frees the buffer
    if (finish) begin
      meta_next.row_end     = 1'b1;
      read_position_next    = '0;
      horizontal_count_next = '0;
      pad_count_next        = '0;
      in_padding_next       = 1'b0;
      if (v_inc >= eff_factor) begin
        meta_next.block_end = 1'b1;
        vertical_count_next = '0;
        row_ready_next      = 1'b0;
        fill_position_next  = '0;
      end else begin
        vertical_count_next = v_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_position    <= '0;
      row_ready        <= 1'b0;
      read_position    <= '0;
      horizontal_count <= '0;
      vertical_count   <= '0;
      pad_count        <= '0;
      in_padding       <= 1'b0;
      s1_valid         <= 1'b0;
    end else begin
      if (accept) begin
        fill_position    <= fill_position_next;
        row_ready        <= row_ready_next;
        read_position    <= read_position_next;
        horizontal_count <= horizontal_count_next;
        vertical_count   <= vertical_count_next;
        pad_count        <= pad_count_next;
        in_padding       <= in_padding_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta_next;
    end
  end

  // ---------------------------------------------------------------- line buffer
  // Writes only happen while no row is ready and read data is only used while one
  // is, so a word never uses the entry written in the same cycle; a write followed
  // by a read on the next cycle sees the new data through the RAM itself. The read
  // data register only moves on accept, so it holds while s1 is stalled.
  ipu_ram #(
    .WIDTH (PixW),
    .DEPTH (MAX_ROW_PIXELS)
  ) u_line_store (
    .clk   (clk),
    .we    (accept && ram_we),
    .waddr (AddrW'(fill_position)),
    .wdata ({item.red, item.green, item.blue}),
    .re    (accept),
    .raddr (AddrW'(read_position)),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res.status    <= s1_meta.status;
      res.row_end   <= s1_meta.row_end;
      res.block_end <= s1_meta.block_end;
      if (s1_meta.status == ST_PIXEL) begin
        res.out_blue  <= ram_rdata[7:0];
        res.out_green <= ram_rdata[15:8];
        res.out_red   <= ram_rdata[23:16];
      end else begin
        res.out_blue  <= PAD_BYTE;
        res.out_green <= PAD_BYTE;
        res.out_red   <= PAD_BYTE;
      end
    end
  end

`ifndef SYNTH
  // buffer is only written while it is being filled
  a_write_only_when_filling: assert property (@(posedge clk) disable iff (rst)
    (accept && ram_we) |-> !row_ready)
    else $error("line buffer written during replay");

  // a block end is always also a row end
  a_block_end_is_row_end: assert property (@(posedge clk) disable iff (rst)
    (accept && meta_next.block_end) |-> meta_next.row_end)
    else $error("block_end without row_end");

  // the last vertical copy frees the buffer
  a_block_end_frees: assert property (@(posedge clk) disable iff (rst)
    (accept && meta_next.block_end) |=> !row_ready && fill_position == '0)
    else $error("buffer not freed after block end");

  // a stalled middle stage keeps its word
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> s1_valid && $stable(s1_meta))
    else $error("middle stage lost or changed a word");
`endif

endmodule

`default_nettype wire
